/* hw/rtl/tcp_fst_pkg.sv */
// Shared types and constants of the TCP flow state tracker.
package tcp_fst_pkg;

    typedef enum logic [2:0] {
        PH_UNKNOWN  = 3'd0,
        PH_OPENING  = 3'd1,
        PH_ESTAB    = 3'd2,
        PH_A_CLOSED = 3'd3,
        PH_B_CLOSED = 3'd4,
        PH_CLOSED   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        DEC_STORED   = 2'd0,
        DEC_DROPPED  = 2'd1,
        DEC_NOT_MINE = 2'd2
    } decision_t;

    localparam int HS_WIDTH = 4;

    // Bit positions inside the handshake vector.
    localparam int HS_SYN_A    = 0;
    localparam int HS_SYN_B    = 1;
    localparam int HS_SYNACK_A = 2;
    localparam int HS_SYNACK_B = 3;

    typedef logic [HS_WIDTH-1:0] handshake_t;

    typedef struct packed {
        logic start_flow;
        logic syn_bit;
        logic ack_bit;
        logic fin_bit;
        logic rst_bit;
        logic from_side_a;
        logic carries_payload;
    } pkt_t;

    typedef struct packed {
        decision_t  decision;
        phase_t     flow_phase;
        handshake_t handshake_seen;
    } res_t;

    typedef struct packed {
        phase_t     phase;
        handshake_t handshake;
    } flow_state_t;

endpackage

/* hw/rtl/tcp_fst_if.sv */
// Valid/ready channel interfaces for packet flags and per-packet results.
interface tcp_fst_pkt_if
    import tcp_fst_pkg::*;
;
    logic valid;
    logic ready;
    pkt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcp_fst_res_if
    import tcp_fst_pkg::*;
;
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tcp_fst_update.sv */
// Flow phase and handshake transition logic for one packet.
module tcp_fst_update
    import tcp_fst_pkg::*;
(
    input  flow_state_t state,
    input  pkt_t        pkt,
    output flow_state_t state_next,
    output decision_t   decision
);

    function automatic phase_t fin_phase(phase_t p, logic dir_a);
        phase_t r;
        if (dir_a)
        begin
            r = (p == PH_B_CLOSED) ? PH_CLOSED : PH_A_CLOSED;
        end
        else
        begin
            r = (p == PH_A_CLOSED) ? PH_CLOSED : PH_B_CLOSED;
        end
        return r;
    endfunction

    // One-hot handshake bit for a SYN or a SYN-ACK from the given side.
    function automatic handshake_t hs_mask(logic dir_a, logic synack);
        handshake_t m;
        m = '0;
        if (synack)
        begin
            if (dir_a)
            begin
                m[HS_SYNACK_A] = 1'b1;
            end
            else
            begin
                m[HS_SYNACK_B] = 1'b1;
            end
        end
        else
        begin
            if (dir_a)
            begin
                m[HS_SYN_A] = 1'b1;
            end
            else
            begin
                m[HS_SYN_B] = 1'b1;
            end
        end
        return m;
    endfunction

    flow_state_t cur;
    logic        from_closed;
    logic        syn_seen;

    // A new flow starts from a clean state before this packet is applied.
    assign cur = pkt.start_flow ? flow_state_t'{phase: PH_UNKNOWN, handshake: '0} : state;

    assign from_closed = (cur.phase == PH_A_CLOSED) ? pkt.from_side_a : !pkt.from_side_a;
    assign syn_seen    = pkt.from_side_a ? cur.handshake[HS_SYN_A] : cur.handshake[HS_SYN_B];

    always_comb
    begin
        state_next = cur;
        decision   = DEC_STORED;
        unique case (cur.phase) inside
            PH_UNKNOWN:
            begin
                if (pkt.fin_bit || pkt.rst_bit)
                begin
                    decision = DEC_DROPPED;
                end
                else if (pkt.syn_bit)
                begin
                    if (pkt.ack_bit)
                    begin
                        state_next.handshake = cur.handshake |
                            hs_mask(pkt.from_side_a, 1'b1);
                        state_next.phase = PH_ESTAB;
                    end
                    else
                    begin
                        state_next.handshake = cur.handshake |
                            hs_mask(pkt.from_side_a, 1'b0);
                        state_next.phase = PH_OPENING;
                    end
                end
                else if (!pkt.ack_bit)
                begin
                    decision = DEC_DROPPED;
                end
                else
                begin
                    state_next.phase = PH_ESTAB;
                end
            end
            PH_OPENING, PH_ESTAB, PH_A_CLOSED, PH_B_CLOSED:
            begin
                if (pkt.fin_bit)
                begin
                    if ((cur.phase == PH_A_CLOSED || cur.phase == PH_B_CLOSED) && from_closed)
                    begin
                        decision = DEC_DROPPED;
                    end
                    else if (!pkt.ack_bit)
                    begin
                        decision = DEC_DROPPED;
                    end
                    else
                    begin
                        state_next.phase = fin_phase(cur.phase, pkt.from_side_a);
                    end
                end
                else if (pkt.syn_bit)
                begin
                    // Only an opening flow accepts a SYN-ACK from a side that sent no SYN.
                    if (cur.phase == PH_OPENING && pkt.ack_bit && !syn_seen)
                    begin
                        state_next.handshake = cur.handshake |
                            hs_mask(pkt.from_side_a, 1'b1);
                        state_next.phase = PH_ESTAB;
                    end
                    else
                    begin
                        state_next.phase = PH_CLOSED;
                        decision         = DEC_NOT_MINE;
                    end
                end
                else if (pkt.rst_bit)
                begin
                    if (!pkt.ack_bit)
                    begin
                        decision = DEC_DROPPED;
                    end
                    else
                    begin
                        state_next.phase = PH_CLOSED;
                    end
                end
                else if ((cur.phase == PH_A_CLOSED || cur.phase == PH_B_CLOSED)
                         && from_closed && pkt.carries_payload)
                begin
                    decision = DEC_NOT_MINE;
                end
                else if (!pkt.ack_bit)
                begin
                    decision = DEC_DROPPED;
                end
                else if (cur.phase == PH_OPENING)
                begin
                    state_next.phase = PH_ESTAB;
                end
            end
            default:
            begin
                // Closed, and the codes that never arise, swallow every packet.
                decision = DEC_NOT_MINE;
            end
        endcase
    end

endmodule

/* hw/rtl/tcp_flow_state_tracker.sv */
// Top level of the TCP flow state tracker: input stage, state and result register.
//
//   Channel | Direction | Payload                                   | Handshake
//   --------+-----------+-------------------------------------------+-----------
//   pkt     | in        | start_flow, SYN/ACK/FIN/RST, side, data   | valid/ready
//   res     | out       | decision, flow_phase, handshake_seen      | valid/ready
//
// Each packet transaction is captured in an input register. When the result register
// is free, the transition logic updates the flow state and loads the result register
// in the same edge, and the result is offered from that register. One transaction per
// cycle is sustained while results are taken, since the state loop closes through a
// single register.
// rst_n clears the flow state to unknown with no handshake bits, and empties both stages.
// When the result is not taken, the input stage still fills, so the block holds up to
// two transactions before it deasserts ready on the packet channel.
module tcp_flow_state_tracker
    import tcp_fst_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    tcp_fst_pkt_if.sink   pkt,
    tcp_fst_res_if.source res
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    pkt_t        s1_data_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    res_t        res_data_reg;
    flow_state_t state_reg;
    flow_state_t state_next;
    decision_t   decision;

    logic accept;
    logic out_free;
    logic commit;

    // The result register can take a new transaction when it is empty or being drained.
    assign out_free = !res_valid_reg || res.ready;
    assign commit   = s1_valid_reg && out_free;
    assign pkt.ready = !s1_valid_reg || out_free;
    assign accept   = pkt.valid && pkt.ready;

    assign s1_valid_next  = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_reg);
    assign res_valid_next = commit ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    tcp_fst_update u_update (
        .state      (state_reg),
        .pkt        (s1_data_reg),
        .state_next (state_next),
        .decision   (decision)
    );

    // The flow state only moves when a transaction passes into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_UNKNOWN, handshake: '0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (commit)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= pkt.data;
        end
        if (commit)
        begin
            res_data_reg.decision       <= decision;
            res_data_reg.flow_phase     <= state_next.phase;
            res_data_reg.handshake_seen <= state_next.handshake;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // The reported phase and handshake bits are the state just written.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (res_data_reg.flow_phase == state_reg.phase
                    && res_data_reg.handshake_seen == state_reg.handshake))
        else $error("result does not match the updated flow state");

    // Without a committed transaction the flow state must hold.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(state_reg))
        else $error("flow state changed without a transaction");

    // Handshake bits only accumulate until a new flow is started.
    a_handshake_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !s1_data_reg.start_flow) |=>
            ((state_reg.handshake & $past(state_reg.handshake)) == $past(state_reg.handshake)))
        else $error("handshake bit cleared within a flow");

    // A closed flow claims nothing and stays closed until a new flow starts.
    a_closed_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !s1_data_reg.start_flow && state_reg.phase == PH_CLOSED) |=>
            (res_data_reg.decision == DEC_NOT_MINE && state_reg.phase == PH_CLOSED))
        else $error("closed flow did not absorb the packet");

endmodule

/* test/tcp_flow_state_tracker_tb.sv */
// Self-checking testbench for the TCP flow state tracker: directed steps, then random flows.
module tcp_flow_state_tracker_tb;
    import tcp_fst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of packet transactions after which the stimulus stops.
    localparam int PKT_TARGET = 1250;

    // Watchdog in clock cycles. The slowest correct run spends the sender gap, the
    // passage through the block and the receiver stall on each packet, so this limit
    // leaves a wide margin.
    localparam int CYCLE_LIMIT = 300000;

    // Mismatch lines beyond this count are only counted, to keep the log short.
    localparam int REPORT_CAP = 200;

    // Extra cycles that the final drain waits after the last owed result, to catch extras.
    localparam int DRAIN_CYCLES = 6;

    // One row of the directed table. Where known_res is set, the expected result is
    // typed in by hand; otherwise the flow predictor supplies it.
    typedef struct {
        pkt_t pkt;
        bit   known_res;
        res_t res;
    } step_t;

    logic clk;
    logic rst_n;

    tcp_fst_pkt_if pkt_ch ();
    tcp_fst_res_if res_ch ();

    tcp_flow_state_tracker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch)
    );

    // Predicted flow state, advanced once per accepted packet transaction.
    phase_t     flow_phase_q;
    handshake_t flow_hs_q;

    // Results that the block still owes, oldest first.
    res_t       pending_results[$];
    step_t      directed_steps[$];

    int         err_count;
    int         pkt_count;
    int         cycle_count;

    // When set, the sender or the receiver runs without idle cycles for a while.
    bit         tx_steady;
    bit         rx_steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // FIN with ACK closes the sending side; with the other side already closed the
    // whole flow closes. Without ACK the packet is dropped and nothing changes.
    function automatic decision_t take_fin(logic ack, logic side_a);
        if (!ack)
            return DEC_DROPPED;
        if (side_a)
        begin
            if (flow_phase_q == PH_B_CLOSED)
                flow_phase_q = PH_CLOSED;
            else
                flow_phase_q = PH_A_CLOSED;
        end
        else
        begin
            if (flow_phase_q == PH_A_CLOSED)
                flow_phase_q = PH_CLOSED;
            else
                flow_phase_q = PH_B_CLOSED;
        end
        return DEC_STORED;
    endfunction

    // RST with ACK closes the flow outright.
    function automatic decision_t take_rst(logic ack);
        if (!ack)
            return DEC_DROPPED;
        flow_phase_q = PH_CLOSED;
        return DEC_STORED;
    endfunction

    // An ordinary ACKed packet establishes a flow that is still unknown or opening.
    // A half closed phase is kept as it is.
    function automatic decision_t take_plain(logic ack);
        if (!ack)
            return DEC_DROPPED;
        if (flow_phase_q == PH_UNKNOWN || flow_phase_q == PH_OPENING)
            flow_phase_q = PH_ESTAB;
        return DEC_STORED;
    endfunction

    // Advances the predicted flow state by one packet and returns the result that
    // the block must produce for it.
    function automatic res_t track_flow(pkt_t p);
        decision_t verdict;
        logic      from_closed;
        logic      syn_known;
        res_t      r;

        if (p.start_flow)
        begin
            flow_phase_q = PH_UNKNOWN;
            flow_hs_q    = '0;
        end

        case (flow_phase_q) inside
            PH_UNKNOWN:
            begin
                if (p.fin_bit || p.rst_bit)
                    verdict = DEC_DROPPED;
                else if (p.syn_bit)
                begin
                    if (p.ack_bit)
                    begin
                        if (p.from_side_a)
                            flow_hs_q[HS_SYNACK_A] = 1'b1;
                        else
                            flow_hs_q[HS_SYNACK_B] = 1'b1;
                        flow_phase_q = PH_ESTAB;
                    end
                    else
                    begin
                        if (p.from_side_a)
                            flow_hs_q[HS_SYN_A] = 1'b1;
                        else
                            flow_hs_q[HS_SYN_B] = 1'b1;
                        flow_phase_q = PH_OPENING;
                    end
                    verdict = DEC_STORED;
                end
                else
                    verdict = take_plain(p.ack_bit);
            end
            PH_OPENING:
            begin
                if (p.fin_bit)
                    verdict = take_fin(p.ack_bit, p.from_side_a);
                else if (p.syn_bit)
                begin
                    // A bare SYN, or a second SYN from the side that already opened,
                    // belongs to some other flow and ends this one.
                    syn_known = p.from_side_a ? flow_hs_q[HS_SYN_A] : flow_hs_q[HS_SYN_B];
                    if (!p.ack_bit || syn_known)
                    begin
                        flow_phase_q = PH_CLOSED;
                        verdict      = DEC_NOT_MINE;
                    end
                    else
                    begin
                        if (p.from_side_a)
                            flow_hs_q[HS_SYNACK_A] = 1'b1;
                        else
                            flow_hs_q[HS_SYNACK_B] = 1'b1;
                        flow_phase_q = PH_ESTAB;
                        verdict      = DEC_STORED;
                    end
                end
                else if (p.rst_bit)
                    verdict = take_rst(p.ack_bit);
                else
                    verdict = take_plain(p.ack_bit);
            end
            PH_ESTAB:
            begin
                if (p.fin_bit)
                    verdict = take_fin(p.ack_bit, p.from_side_a);
                else if (p.syn_bit)
                begin
                    flow_phase_q = PH_CLOSED;
                    verdict      = DEC_NOT_MINE;
                end
                else if (p.rst_bit)
                    verdict = take_rst(p.ack_bit);
                else
                    verdict = take_plain(p.ack_bit);
            end
            PH_A_CLOSED, PH_B_CLOSED:
            begin
                from_closed = (flow_phase_q == PH_A_CLOSED) ? p.from_side_a : !p.from_side_a;
                if (p.fin_bit)
                    verdict = from_closed ? DEC_DROPPED : take_fin(p.ack_bit, p.from_side_a);
                else if (p.syn_bit)
                begin
                    flow_phase_q = PH_CLOSED;
                    verdict      = DEC_NOT_MINE;
                end
                else if (p.rst_bit)
                    verdict = take_rst(p.ack_bit);
                else if (from_closed && p.carries_payload)
                    verdict = DEC_NOT_MINE;
                else
                    verdict = take_plain(p.ack_bit);
            end
            default:
                // Closed, and the codes that can never arise, swallow every packet.
                verdict = DEC_NOT_MINE;
        endcase

        r.decision       = verdict;
        r.flow_phase     = flow_phase_q;
        r.handshake_seen = flow_hs_q;
        return r;
    endfunction

    // Builds one packet of a random flow. The first packet of a flow starts it and
    // is mostly a SYN; later packets are mostly ACKed, with FINs common enough that
    // flows run through both half closes, and SYN and RST rare. One packet in ten
    // is plain noise with every flag random, which also restarts flows mid-way.
    function automatic pkt_t random_pkt(bit first);
        pkt_t p;

        if ($urandom_range(0, 9) == 0)
        begin
            p = pkt_t'(7'($urandom_range(0, 127)));
            return p;
        end
        p.start_flow      = first;
        p.syn_bit         = first ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 7) == 0);
        p.ack_bit         = first ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) != 0);
        p.fin_bit         = !p.syn_bit && ($urandom_range(0, 5) == 0);
        p.rst_bit         = ($urandom_range(0, 15) == 0);
        p.from_side_a     = ($urandom_range(0, 1) == 1);
        p.carries_payload = ($urandom_range(0, 1) == 1);
        return p;
    endfunction

    // Appends a row to the directed table. Flags are given in the order of pkt_t:
    // start_flow, SYN, ACK, FIN, RST, side A, payload.
    task automatic add_step(input logic [6:0] flags, input bit known_res,
                            input decision_t dec, input phase_t ph, input handshake_t hs);
        step_t s;

        s.pkt                = pkt_t'(flags);
        s.known_res          = known_res;
        s.res.decision       = dec;
        s.res.flow_phase     = ph;
        s.res.handshake_seen = hs;
        directed_steps.push_back(s);
    endtask

    // Offers one packet transaction after a random gap and waits until the block
    // takes it. valid stays high across back-to-back transactions.
    task automatic send_pkt(input pkt_t p, input bit known_res, input res_t known);
        int   gap;
        res_t predicted;

        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.data  <= p;
        do
            @(posedge clk);
        while (!pkt_ch.ready);

        predicted = track_flow(p);
        pending_results.push_back(known_res ? known : predicted);
        pkt_count++;
    endtask

    // Compares one result transaction with the oldest outstanding expectation.
    task automatic check_result(input res_t got);
        res_t want;

        if (pending_results.size() == 0)
        begin
            err_count++;
            if (err_count <= REPORT_CAP)
                $display("%0t: unexpected result transaction, actual dec=%0d phase=%0d hs=%b",
                         $time, got.decision, got.flow_phase, got.handshake_seen);
            return;
        end
        want = pending_results.pop_front();
        if (got.decision !== want.decision || got.flow_phase !== want.flow_phase ||
            got.handshake_seen !== want.handshake_seen)
        begin
            err_count++;
            if (err_count <= REPORT_CAP)
                $display({"%0t: result mismatch, expected dec=%0d phase=%0d hs=%b, ",
                          "actual dec=%0d phase=%0d hs=%b"},
                         $time, want.decision, want.flow_phase, want.handshake_seen,
                         got.decision, got.flow_phase, got.handshake_seen);
        end
    endtask

    // Result side: after a random stall the testbench raises ready and takes the
    // next result transaction. ready stays high when no stall is drawn.
    initial
    begin
        int stall;

        res_ch.ready <= 1'b0;
        rx_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            check_result(res_ch.data);
        end
    end

    // Watchdog: a run that hangs is a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int   flow_len;
        res_t no_res;

        rst_n        <= 1'b0;
        pkt_ch.valid <= 1'b0;
        pkt_ch.data  <= '0;
        err_count    = 0;
        pkt_count    = 0;
        tx_steady    = 1'b0;
        flow_phase_q = PH_UNKNOWN;
        flow_hs_q    = '0;
        no_res       = '0;

        // Directed part. It walks every phase and these rules: FIN, RST and bare
        // ACK-less packets before a handshake, SYN opening and SYN-ACK completing,
        // the repeated SYN from one side, the absorbing closed phase, start_flow
        // restarts, both half closes, the dropped FIN and foreign payload of side A's
        // half close, and the final close from side B.
        add_step(7'b0_0_0_1_0_1_0, 1, DEC_DROPPED,  PH_UNKNOWN, '0);
        add_step(7'b0_0_0_0_1_0_0, 1, DEC_DROPPED,  PH_UNKNOWN, '0);
        add_step(7'b0_0_0_0_0_1_1, 1, DEC_DROPPED,  PH_UNKNOWN, '0);
        add_step(7'b0_1_0_0_0_1_0, 1, DEC_STORED,   PH_OPENING, handshake_t'(1 << HS_SYN_A));
        add_step(7'b0_1_1_0_0_1_0, 1, DEC_NOT_MINE, PH_CLOSED,  handshake_t'(1 << HS_SYN_A));
        add_step(7'b0_1_1_1_1_0_1, 1, DEC_NOT_MINE, PH_CLOSED,  handshake_t'(1 << HS_SYN_A));
        add_step(7'b1_1_0_0_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_1_1_0_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_0_0_1_1, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_0_1_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_1_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_0_0_1_1, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_0_0_0_1, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_1_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_1_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b1_1_1_0_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_1_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_0_0_1_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_1_0_0_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b1_0_1_0_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_0_1_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b1_1_0_0_0_0_1, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_1_0_0_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b1_1_0_0_0_1_0, 0, DEC_STORED, PH_UNKNOWN, '0);
        add_step(7'b0_0_1_1_0_0_0, 0, DEC_STORED, PH_UNKNOWN, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_pkt(directed_steps[i].pkt, directed_steps[i].known_res,
                     directed_steps[i].res);

        // Random part: whole flows of random length, each opened by start_flow unless its
        // first packet is noise, so that most packets land in the opening, established and
        // half closed phases rather than in the closed one.
        while (pkt_count < PKT_TARGET)
        begin
            flow_len = $urandom_range(4, 24);
            for (int k = 0; k < flow_len; k++)
                send_pkt(random_pkt(k == 0), 1'b0, no_res);
        end

        pkt_ch.valid <= 1'b0;

        // Wait for every owed result, then a few more cycles to catch extras.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
